FILE: rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and codes for the positional list core: transfer payloads,
// request and status codes, and the command broadcast to the storage cells.
// ----------------------------------------------------------------------------
package pli_pkg;

    // request codes
    localparam logic [1:0] ACT_PUSH   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [4:0]         position;
        logic signed [31:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic [1:0]         status;
        logic [4:0]         length_now;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
    } t_cell_cmd;

endpackage

FILE: rtl/pli_cell.sv
// ----------------------------------------------------------------------------
// pli_cell
// One storage slot of the list. Compares its own index with the broadcast
// position and takes its next value from the left neighbor, the right
// neighbor, the new item, or itself.
// ----------------------------------------------------------------------------
module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0,
    parameter int PW  = 5
) (
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic [PW-1:0]      i_pos,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_value
);

    localparam logic [PW-1:0] IDX_V = PW'(IDX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            OP_INSERT: begin
                // open a gap at the position, shift the tail up
                if (IDX_V == i_pos) begin
                    n_value = i_cmd.value;
                end else if (IDX_V > i_pos) begin
                    n_value = i_left;
                end
            end
            OP_DELETE: begin
                // close the gap, shift the tail down
                if (IDX_V >= i_pos) begin
                    n_value = i_right;
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/positional_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core
// Ordered list of signed 32-bit values with push, insert-at and delete-at,
// held in a row of cells that shift toward or away from the target index.
//
//   channel   direction   handshake                 payload
//   request   in          i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   result    out         o_out_valid / i_out_ready o_out_data (t_out_item)
//
// On each accepted request all cells shift in parallel at the accepting edge
// and the result lands in the output register on the same edge.
// Sustained rate is one transfer per cycle while the result side keeps ready;
// the output register is the only stage between the sides. A new request is
// taken whenever the output register is empty or being drained. Synchronous
// active-low reset empties the list and holds the request side not ready;
// cell contents are not cleared (only entries below the count are ever read).
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core
    import pli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 5) ? CW : 5;
    localparam int IW = $clog2(CAPACITY);
    localparam logic [PW-1:0] CAP_V = PW'(CAPACITY);

    logic [CW-1:0]      r_count;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               w_take;
    logic [PW-1:0]      w_pos;
    logic [PW-1:0]      w_cnt;
    logic [PW-1:0]      w_new_cnt;
    logic [PW-1:0]      w_cell_pos;
    t_cell_cmd          w_cmd;
    t_out_item          n_out;
    logic signed [31:0] w_entry [CAPACITY];

    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign w_take     = i_in_valid && o_in_ready;

    always_comb begin
        w_pos               = PW'(i_in_data.position);
        w_cnt               = PW'(r_count);
        w_new_cnt           = w_cnt;
        w_cell_pos          = w_pos;
        w_cmd.op            = OP_HOLD;
        w_cmd.value         = i_in_data.item_value;
        n_out.removed_value = '0;
        n_out.status        = ST_OK;
        case (i_in_data.action)
            ACT_PUSH: begin
                if (w_cnt >= CAP_V) begin
                    n_out.status = ST_FULL;
                end else begin
                    w_cmd.op   = OP_INSERT;
                    w_cell_pos = w_cnt;
                    w_new_cnt  = w_cnt + 1'b1;
                end
            end
            ACT_INSERT: begin
                if (w_cnt >= CAP_V) begin
                    n_out.status = ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_out.status = ST_RANGE;
                end else begin
                    w_cmd.op  = OP_INSERT;
                    w_new_cnt = w_cnt + 1'b1;
                end
            end
            ACT_DELETE: begin
                if (w_pos >= w_cnt) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.removed_value = w_entry[w_pos[IW-1:0]];
                    w_cmd.op            = OP_DELETE;
                    w_new_cnt           = w_cnt - 1'b1;
                end
            end
            default: n_out.status = ST_RANGE;
        endcase
        n_out.length_now = w_new_cnt[4:0];
        // hold the cells unless a request transfers this cycle
        if (!w_take) begin
            w_cmd.op = OP_HOLD;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] w_left;
            logic signed [31:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[g+1];
            end
            pli_cell #(
                .IDX (g),
                .PW  (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_pos   (w_cell_pos),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_entry[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count     <= CW'(w_new_cnt);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_count) <= CAP_V)
        else $error("list count exceeds capacity");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && n_out.status == ST_OK &&
         (i_in_data.action == ACT_PUSH || i_in_data.action == ACT_INSERT))
        |=> r_count == CW'($past(r_count) + 1'b1))
        else $error("successful insert did not grow the list by one");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && n_out.status == ST_FULL) |-> PW'(r_count) == CAP_V)
        else $error("full status on a list that is not full");

    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_OK) |-> o_out_data.removed_value == '0)
        else $error("removed value nonzero on a failed request");
`endif

endmodule

FILE: tb/sv/positional_list_insert_delete_core_test.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core_test
// Self-checking bench for the positional list core. A scoreboard keeps its own
// copy of the list, predicts status, removed value and length for every
// request transfer, and checks each result transfer in order. Stimulus is a
// directed pass over the corner cases followed by random grow and shrink
// phases, with random idle bursts on both channels and one long result stall.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core_test;
    import pli_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = 16;
    localparam int          RANDOM_ITEMS = 740;
    localparam int          CALM_ITEMS   = 100;
    localparam int          LONG_HOLD    = 300;
    localparam int          DRAIN_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam logic [1:0]  ACT_UNUSED   = 2'd3;

    class list_scoreboard;
        logic signed [31:0] cells [LIST_DEPTH];
        int unsigned        count;
        t_out_item          pending [$];
        int                 errors;
        int                 checked;
        int                 n_ok;
        int                 n_range;
        int                 n_full;
        int                 peak;

        task report(input string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(input t_in_item req);
            t_out_item res;
            int        k;
            res.removed_value = '0;
            res.status        = ST_OK;
            case (req.action)
                ACT_PUSH: begin
                    if (count >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        cells[count] = req.item_value;
                        count++;
                    end
                end
                ACT_INSERT: begin
                    if (count >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else if (req.position > count) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (k = count; k > req.position; k--) cells[k] = cells[k-1];
                        cells[req.position] = req.item_value;
                        count++;
                    end
                end
                ACT_DELETE: begin
                    if (req.position >= count) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.removed_value = cells[req.position];
                        for (k = req.position; k + 1 < count; k++) cells[k] = cells[k+1];
                        count--;
                    end
                end
                default: begin
                    res.status = ST_RANGE;
                end
            endcase
            res.length_now = count[4:0];
            case (res.status)
                ST_OK:    n_ok++;
                ST_RANGE: n_range++;
                default:  n_full++;
            endcase
            if (count > peak) peak = count;
            pending.push_back(res);
        endfunction

        task check_result(input t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report($sformatf("result with nothing pending: %p", got));
            end else begin
                want = pending.pop_front();
                if (got.removed_value !== want.removed_value)
                    report($sformatf("result %0d removed_value %0d, expected %0d",
                        checked, got.removed_value, want.removed_value));
                if (got.status !== want.status)
                    report($sformatf("result %0d status %0d, expected %0d",
                        checked, got.status, want.status));
                if (got.length_now !== want.length_now)
                    report($sformatf("result %0d length_now %0d, expected %0d",
                        checked, got.length_now, want.length_now));
            end
            checked++;
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    list_scoreboard scb = new();
    bit             idle_on       = 1'b1;
    bit             long_hold_req = 1'b0;
    int             hold_done     = 0;
    int             cycle_count   = 0;

    positional_list_insert_delete_core #(
        .CAPACITY(LIST_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending",
                cycle_count, scb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            scb.check_result(o_out_data);
    end

    function automatic t_in_item make_req(input logic [1:0] act, input logic [4:0] pos,
                                          input logic signed [31:0] val);
        t_in_item req;
        req.action     = act;
        req.position   = pos;
        req.item_value = val;
        return req;
    endfunction

    // Hold valid and payload until the transfer happens.
    task automatic send_request(input t_in_item req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        scb.note_request(req);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests for the current length, some noise.
    function automatic t_in_item pick_request(input bit grow);
        int         r;
        logic [1:0] act;
        logic [4:0] pos;
        r = $urandom_range(0, 99);
        if (r < 3)                act = ACT_UNUSED;
        else if (r < (grow ? 45 : 15)) act = ACT_PUSH;
        else if (r < (grow ? 85 : 30)) act = ACT_INSERT;
        else                      act = ACT_DELETE;
        if ($urandom_range(0, 9) == 0 || act == ACT_PUSH || act == ACT_UNUSED)
            pos = 5'($urandom_range(0, 31));
        else if (act == ACT_INSERT)
            pos = 5'($urandom_range(0, scb.count));
        else
            pos = (scb.count == 0) ? 5'd0 : 5'($urandom_range(0, scb.count - 1));
        return make_req(act, pos, pick_value());
    endfunction

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                hold_done = 0;
                while (hold_done < LONG_HOLD) begin
                    @(posedge i_clk);
                    hold_done++;
                end
                long_hold_req = 1'b0;
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in_item directed [$];
        bit       grow;
        int       n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list corner cases
        directed.push_back(make_req(ACT_DELETE, 5'd0, 32'sd5));
        directed.push_back(make_req(ACT_DELETE, 5'd31, -32'sd1));
        directed.push_back(make_req(ACT_UNUSED, 5'd31, -32'sd1));
        directed.push_back(make_req(ACT_INSERT, 5'd1, 32'sd7));
        // build up, inserting at front, tail and middle
        directed.push_back(make_req(ACT_INSERT, 5'd0, 32'sh8000_0000));
        directed.push_back(make_req(ACT_PUSH, 5'd31, 32'sh7FFF_FFFF));
        directed.push_back(make_req(ACT_INSERT, 5'd2, -32'sd1));
        directed.push_back(make_req(ACT_INSERT, 5'd1, 32'sd0));
        for (n = 0; n < 12; n++)
            directed.push_back(make_req(ACT_PUSH, n[4:0], $urandom));
        // full list: push and insert refused, full wins over a bad position
        directed.push_back(make_req(ACT_PUSH, 5'd0, 32'sd1));
        directed.push_back(make_req(ACT_INSERT, 5'd0, 32'sd2));
        directed.push_back(make_req(ACT_INSERT, 5'd31, 32'sd3));
        directed.push_back(make_req(ACT_DELETE, 5'd16, 32'sd0));
        directed.push_back(make_req(ACT_DELETE, 5'd15, 32'sd0));
        directed.push_back(make_req(ACT_DELETE, 5'd0, 32'sd0));
        directed.push_back(make_req(ACT_UNUSED, 5'd3, 32'sd9));
        directed.push_back(make_req(ACT_INSERT, 5'd15, 32'sd4));
        directed.push_back(make_req(ACT_INSERT, 5'd14, 32'sd5));
        directed.push_back(make_req(ACT_DELETE, 5'd7, 32'sd0));
        foreach (directed[i]) begin
            send_request(directed[i]);
            sender_gap();
        end

        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) grow = ~grow;
            if (n == 300) long_hold_req = 1'b1;
            if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
            send_request(pick_request(grow));
            sender_gap();
        end
        i_in_valid <= 1'b0;

        while (scb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scb.pending.size() != 0)
            scb.report($sformatf("%0d expected results never arrived", scb.pending.size()));

        $display("Covered %0d requests: %0d ok, %0d out of range or empty, %0d on a full list",
            scb.n_ok + scb.n_range + scb.n_full, scb.n_ok, scb.n_range, scb.n_full);
        $display("Longest list %0d of %0d; result side held off %0d cycles in one stretch",
            scb.peak, LIST_DEPTH, LONG_HOLD);
        if (scb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", scb.errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
